@@ hw/rtl/ssm_pkg.sv @@
// shared types and constants for the streamed substring search
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int PATTERN_MAX = 16;
  localparam int TEXT_MAX    = 65536;

  localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int COUNT_W = $clog2(TEXT_MAX + 1);
  localparam int POS_W   = 16;
  localparam int BYTE_W  = 8;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_END    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [BYTE_W-1:0] character;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } out_t;

  // per-beat controls broadcast to every cell
  typedef struct packed {
    logic shift_pat;
    logic shift_text;
    logic clr_pat;
    logic clr_text;
  } cell_ctl_t;

endpackage

@@ hw/rtl/ssm_cell.sv @@
// one cell: a pattern byte and a text byte, both shifting toward the next cell
`timescale 1ns / 1ps

module ssm_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  ssm_pkg::cell_ctl_t        ctl,
  input  logic [ssm_pkg::BYTE_W-1:0] q_in,
  input  logic                      qv_in,
  input  logic [ssm_pkg::BYTE_W-1:0] w_in,
  input  logic                      wv_in,
  output logic [ssm_pkg::BYTE_W-1:0] q_out,
  output logic                      qv_out,
  output logic [ssm_pkg::BYTE_W-1:0] w_out,
  output logic                      wv_out,
  output logic                      hit
);

  logic [ssm_pkg::BYTE_W-1:0] q;
  logic                       qv;
  logic [ssm_pkg::BYTE_W-1:0] w;
  logic                       wv;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
      wv <= 1'b0;
    end else begin
      if (ctl.clr_pat) begin
        qv <= 1'b0;
      end else if (ctl.shift_pat) begin
        qv <= qv_in;
      end
      if (ctl.clr_text) begin
        wv <= 1'b0;
      end else if (ctl.shift_text) begin
        wv <= wv_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift_pat) begin
      q <= q_in;
    end
    if (ctl.shift_text) begin
      w <= w_in;
    end
  end

  // compare against the byte that lands here on this text beat
  assign hit    = !qv || (wv_in && (q == w_in));
  assign q_out  = q;
  assign qv_out = qv;
  assign w_out  = w;
  assign wv_out = wv;

endmodule

@@ hw/rtl/substring_first_match.sv @@
// top level of the streamed first-occurrence substring search
//
// input channel (in_valid, in_stall, in_data): each beat carries a mode and a
// byte: clear the pattern, append one pattern byte, deliver one text byte, or
// end the text. output channel (out_valid, out_stall, out_data): one beat per
// end-of-text beat, giving found, the start position of the first match and
// the text overflow flag.
// a chain of PATTERN_MAX cells holds the pattern, newest byte in cell 0, and
// the most recent text bytes, newest in cell 0, so each cell compares one
// pattern byte with one text byte; the cell hits are and-ed in the same cycle.
// throughput: one beat per cycle of any mode while no end-of-text beat is held
// off, the compare across the cell row being combinational. latency: the result
// beat is valid the cycle after the end-of-text beat is accepted.
// when the receiver stalls, the result waits in the output register; clear,
// append and text beats keep flowing, only a further end-of-text beat is held
// off until the waiting result is taken.
// reset empties the pattern, rearms the text search and drops out_valid.
`timescale 1ns / 1ps

module substring_first_match (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssm_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ssm_pkg::out_t out_data
);

  localparam int N = ssm_pkg::PATTERN_MAX;

  // search state
  logic [ssm_pkg::LEN_W-1:0]   pat_len;
  logic [ssm_pkg::COUNT_W-1:0] text_count;
  logic                        match_seen;
  logic [ssm_pkg::POS_W-1:0]   match_start;
  logic                        overflow_seen;

  // cell row links
  logic [ssm_pkg::BYTE_W-1:0] q_link [N];
  logic [ssm_pkg::BYTE_W-1:0] w_link [N];
  logic [N-1:0]               qv_link;
  logic [N-1:0]               wv_link;
  logic [N-1:0]               hits;

  ssm_pkg::cell_ctl_t ctl;

  logic                        accept;
  logic                        is_clear;
  logic                        is_append;
  logic                        is_text;
  logic                        is_end;
  logic                        text_full;
  logic                        pat_full;
  logic                        record;
  logic [ssm_pkg::COUNT_W-1:0] count_inc;

  // only an end beat needs the output register free
  assign in_stall = out_valid && out_stall && (in_data.mode == ssm_pkg::MODE_END);
  assign accept   = in_valid && !in_stall;

  assign is_clear  = accept && (in_data.mode == ssm_pkg::MODE_CLEAR);
  assign is_append = accept && (in_data.mode == ssm_pkg::MODE_APPEND);
  assign is_text   = accept && (in_data.mode == ssm_pkg::MODE_TEXT);
  assign is_end    = accept && (in_data.mode == ssm_pkg::MODE_END);

  assign text_full = (text_count >= ssm_pkg::COUNT_W'(ssm_pkg::TEXT_MAX));
  assign pat_full  = (pat_len == ssm_pkg::LEN_W'(N));

  assign ctl.shift_pat  = is_append && !pat_full;
  assign ctl.shift_text = is_text && !text_full;
  assign ctl.clr_pat    = is_clear;
  assign ctl.clr_text   = is_clear || is_end;

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      logic [ssm_pkg::BYTE_W-1:0] q_src;
      logic                       qv_src;
      logic [ssm_pkg::BYTE_W-1:0] w_src;
      logic                       wv_src;

      if (i == 0) begin : g_head
        // new bytes enter at the head of the row
        assign q_src  = in_data.character;
        assign qv_src = 1'b1;
        assign w_src  = in_data.character;
        assign wv_src = 1'b1;
      end else begin : g_body
        assign q_src  = q_link[i-1];
        assign qv_src = qv_link[i-1];
        assign w_src  = w_link[i-1];
        assign wv_src = wv_link[i-1];
      end

      ssm_cell u_cell (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .q_in   (q_src),
        .qv_in  (qv_src),
        .w_in   (w_src),
        .wv_in  (wv_src),
        .q_out  (q_link[i]),
        .qv_out (qv_link[i]),
        .w_out  (w_link[i]),
        .wv_out (wv_link[i]),
        .hit    (hits[i])
      );
    end
  endgenerate

  assign count_inc = text_count + ssm_pkg::COUNT_W'(1);

  // first full match of a non-empty pattern, before any overflow
  assign record = ctl.shift_text && !match_seen && !overflow_seen &&
                  (pat_len != '0) && (&hits);

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_len       <= '0;
      text_count    <= '0;
      match_seen    <= 1'b0;
      overflow_seen <= 1'b0;
    end else begin
      if (is_clear) begin
        pat_len <= '0;
      end else if (ctl.shift_pat) begin
        pat_len <= pat_len + ssm_pkg::LEN_W'(1);
      end

      if (ctl.clr_text) begin
        text_count    <= '0;
        match_seen    <= 1'b0;
        overflow_seen <= 1'b0;
      end else if (is_text) begin
        if (text_full) begin
          overflow_seen <= 1'b1;
        end else begin
          text_count <= count_inc;
        end
        if (record) begin
          match_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clr_text) begin
      match_start <= '0;
    end else if (record) begin
      match_start <= ssm_pkg::POS_W'(count_inc - ssm_pkg::COUNT_W'(pat_len));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (is_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_end) begin
      if (pat_len == '0) begin
        out_data.found    <= 1'b1;
        out_data.position <= '0;
      end else begin
        out_data.found    <= match_seen;
        out_data.position <= match_seen ? match_start : '0;
      end
      out_data.overflow <= overflow_seen;
    end
  end

  // a recorded match always belongs to a non-empty pattern
  a_match_has_pattern : assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (pat_len != '0))
    else $error("match recorded with empty pattern");

  // pattern length counter agrees with the cell valid bits
  a_len_matches_cells : assert property (@(posedge clk) disable iff (rst)
    $countones(qv_link) == int'(pat_len))
    else $error("pattern length out of step with cell row");

  // the text count saturates at the limit
  a_count_bounded : assert property (@(posedge clk) disable iff (rst)
    text_count <= ssm_pkg::COUNT_W'(ssm_pkg::TEXT_MAX))
    else $error("text count past limit");

  // an end beat produces a result and rearms the search
  a_end_rearms : assert property (@(posedge clk) disable iff (rst)
    is_end |=> (out_valid && !match_seen && !overflow_seen && (text_count == '0)))
    else $error("end of text did not rearm");

  // input is held off only while a result waits
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the streamed first-occurrence substring search
`timescale 1ns / 1ps

module tb;
  import ssm_pkg::*;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  substring_first_match dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // beats waiting to go out, and search reports the block still owes us
  in_t  beats_to_send [$];
  out_t reports_due [$];

  // pattern as the stimulus has built it so far, used to plant copies in text
  logic [7:0] motif [$];
  int sent_beats = 0;

  // once set, neither side idles any more
  bit calm = 1'b0;
  int errors = 0;

  // ---------------------------------------------------------------------------
  // predictor state: pattern bytes, newest text bytes (index 0 newest), text
  // length, first hit and the sticky overflow flag
  // ---------------------------------------------------------------------------
  logic [7:0]         pat_bytes [PATTERN_MAX];
  logic [LEN_W-1:0]   pat_len = '0;
  logic [7:0]         recent [PATTERN_MAX];
  logic [COUNT_W-1:0] text_len = '0;
  bit                 hit_seen = 1'b0;
  logic [COUNT_W-1:0] hit_at = '0;
  bit                 spilled = 1'b0;

  // a new text starts: window, count, hit and overflow all go back to zero
  function automatic void rearm_text();
    for (int k = 0; k < PATTERN_MAX; k++) recent[k] = 8'h00;
    text_len = '0;
    hit_seen = 1'b0;
    hit_at   = '0;
    spilled  = 1'b0;
  endfunction

  // applies one accepted beat to the predictor; end of text queues a report
  function automatic void search_step(input in_t b);
    out_t r;
    bit   same;
    case (b.mode)
      MODE_CLEAR: begin
        pat_len = '0;
        rearm_text();
      end
      MODE_APPEND: begin
        // a full pattern simply drops further bytes
        if (pat_len < PATTERN_MAX) begin
          pat_bytes[pat_len] = b.character;
          pat_len = pat_len + 1'b1;
        end
      end
      MODE_TEXT: begin
        if (text_len >= TEXT_MAX) begin
          // count saturates; from here on no hit can be recorded
          spilled = 1'b1;
        end else begin
          for (int k = PATTERN_MAX - 1; k > 0; k--) recent[k] = recent[k-1];
          recent[0] = b.character;
          text_len  = text_len + 1'b1;
          if (!hit_seen && !spilled && pat_len != 0 && text_len >= pat_len) begin
            // oldest pattern byte lines up with the oldest byte of the window
            same = 1'b1;
            for (int j = 0; j < pat_len; j++)
              if (pat_bytes[j] != recent[pat_len-1-j]) same = 1'b0;
            if (same) begin
              hit_seen = 1'b1;
              hit_at   = text_len - pat_len;
            end
          end
        end
      end
      MODE_END: begin
        r.found    = (pat_len == 0) || hit_seen;
        r.position = (pat_len != 0 && hit_seen) ? hit_at[POS_W-1:0] : '0;
        r.overflow = spilled;
        reports_due.push_back(r);
        rearm_text();
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: sample both channels at the rising edge, check results against
  // the oldest report due, then feed an accepted input beat to the predictor
  // ---------------------------------------------------------------------------
  bit   in_took = 1'b0;
  out_t want;

  always @(posedge clk) begin
    in_took <= !rst && in_valid && !in_stall;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("result beat with no report due: found %0d position %0d overflow %0d",
                 out_data.found, out_data.position, out_data.overflow);
          errors++;
        end else begin
          want = reports_due.pop_front();
          if (out_data.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_data.found);
            errors++;
          end
          if (out_data.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_data.position);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, out_data.overflow);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) search_step(in_data);
    end
  end

  // ---------------------------------------------------------------------------
  // driver: a beat is held until taken; between beats the sender may go quiet
  // for a random burst
  // ---------------------------------------------------------------------------
  int in_gap = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 9);
        in_valid <= 1'b0;
      end else if (beats_to_send.size() > 0) begin
        in_valid <= 1'b1;
        in_data  <= beats_to_send.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure in random bursts
  int out_gap = 0;

  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send(input mode_t m, input logic [7:0] c);
    in_t b;
    bit  dropped;
    b.mode      = m;
    b.character = c;
    dropped = (m == MODE_APPEND) && (motif.size() >= PATTERN_MAX);
    beats_to_send.push_back(b);
    if (m == MODE_CLEAR) motif.delete();
    else if (m == MODE_APPEND && !dropped) motif.push_back(c);
    if (!dropped) sent_beats++;
  endtask

  // mostly a three-letter alphabet around base so hits are common
  function automatic logic [7:0] letter(input logic [7:0] base);
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return base + 8'($urandom_range(0, 2));
  endfunction

  // one random round: usually a fresh or kept pattern, a short text with
  // planted whole or cut copies of it and a rare append mid-text, then end;
  // now and then plain noise of any mode
  task automatic random_round();
    int n;
    int plen;
    int tlen;
    int cut;
    logic [7:0] base;
    base = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send(mode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) != 0) begin
        send(MODE_CLEAR, 8'($urandom_range(0, 255)));
        // some patterns run past the store so the surplus appends drop
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
        repeat (plen) send(MODE_APPEND, letter(base));
      end
      tlen = $urandom_range(0, 30);
      for (int i = 0; i < tlen; i++) begin
        case ($urandom_range(0, 14))
          0, 1: begin
            if (motif.size() > 0) begin
              cut = ($urandom_range(0, 1) == 0) ? motif.size() : $urandom_range(1, motif.size());
              for (int j = 0; j < cut; j++) send(MODE_TEXT, motif[j]);
            end
          end
          2: send(MODE_APPEND, letter(base));
          default: send(MODE_TEXT, letter(base));
        endcase
      end
      send(MODE_END, 8'($urandom_range(0, 255)));
    end
  endtask

  // hold the sender until every queued beat is taken and every report is in
  task automatic drain();
    while (beats_to_send.size() > 0 || in_valid || reports_due.size() > 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < PATTERN_MAX; k++) pat_bytes[k] = 8'h00;
    rearm_text();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pattern with an empty text, then with a nonempty one
    send(MODE_END, 8'hFF);
    send(MODE_TEXT, 8'hFF);
    send(MODE_END, 8'h00);
    // zero byte as ordinary data, hit one byte in
    send(MODE_APPEND, 8'h00);
    send(MODE_APPEND, 8'hFF);
    send(MODE_TEXT, 8'h00);
    send(MODE_TEXT, 8'h00);
    send(MODE_TEXT, 8'hFF);
    send(MODE_END, 8'h00);
    // pattern survives end of text; empty text then misses
    send(MODE_END, 8'h55);
    // pattern grows while text is streaming
    send(MODE_CLEAR, 8'hAA);
    send(MODE_APPEND, 8'h61);
    send(MODE_TEXT, 8'h62);
    send(MODE_APPEND, 8'h62);
    send(MODE_TEXT, 8'h61);
    send(MODE_TEXT, 8'h62);
    send(MODE_END, 8'h00);
    // clear mid-text rearms the search and empties the pattern
    send(MODE_APPEND, 8'h01);
    send(MODE_TEXT, 8'h01);
    send(MODE_CLEAR, 8'h00);
    send(MODE_END, 8'h00);
    drain();

    while (sent_beats < 1250) random_round();
    drain();

    // closing rounds run without idling on either side
    calm = 1'b1;
    repeat (5) random_round();
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0) begin
      $display("** substring_first_match: PASSED **");
    end else begin
      $display("** substring_first_match: FAILED **");
    end
    $finish;
  end

  // hard limit well past the slowest correct run
  initial begin
    #20ms;
    $display("** substring_first_match: FAILED **");
    $finish;
  end

endmodule
